// ===== rtl/smalu_pkg.sv =====
// ---------------------------------------------------------------------------
// smalu_pkg: shared types and constants for the sign-magnitude ALU
// Holds the operation codes, operand widths and the divider stage state.
// ---------------------------------------------------------------------------
package smalu_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned MAG_W  = 31;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // One divider stage: running remainder, quotient bits, divisor, sign, divide-by-zero flag
   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [MAG_W-1:0] quo;
      logic [MAG_W-1:0] dvs;
      logic             sign;
      logic             dz;
   } div_stage_type;

endpackage

// ===== rtl/sign_magnitude_alu.sv =====
// ---------------------------------------------------------------------------
// sign_magnitude_alu: 32-bit sign-magnitude add, subtract, multiply, divide
// ---------------------------------------------------------------------------
// Usage: present cmd and two sign-magnitude operands on the req_ channel
// (bit 31 sign, bits 30..0 magnitude). Each accepted beat yields exactly one
// rsp_ beat carrying the result and a divide-by-zero flag, in order.
// A beat passes one input stage, 31 divider stages (one quotient bit each)
// and the output register before rsp_tvalid rises.
// All operations travel the same pipeline so order holds.
// Throughput is one beat per cycle. The whole pipeline advances together
// whenever the output register is empty or being taken, so a stalled
// receiver freezes every stage and req_tready drops; nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
// Add and subtract finish in the input stage, multiply merges its
// registered product into the second slot, and all of them ride the divider
// slots unchanged (the divider result is used only for divide beats).
// ---------------------------------------------------------------------------
module sign_magnitude_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result
   output logic        rsp_tuser    // divide_by_zero
);
   import smalu_pkg::*;

   localparam int unsigned DEPTH = MAG_W + 1;

   logic             advance;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             is_div_ff [DEPTH];
   logic [31:0]      fast_ff [DEPTH];
   logic [31:0]      fast_in;
   logic [31:0]      prod_ff;
   logic             out_vld_ff;
   logic [31:0]      out_data_ff;
   logic             out_dz_ff;
   div_stage_type    div_in, div_out;

   logic [MAG_W-1:0] ma, mb;
   logic             na, nb;
   logic [MAG_W:0]   sum_w;
   logic [MAG_W:0]   a_m_b, b_m_a;
   op_type           op;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   assign op = op_type'(req_tuser);
   assign na = req_tdata[31];
   assign nb = req_tdata[63];
   assign ma = req_tdata[30:0];
   assign mb = req_tdata[62:32];
   assign sum_w = {1'b0, ma} + {1'b0, mb};
   assign a_m_b = {1'b0, ma} - {1'b0, mb};
   assign b_m_a = {1'b0, mb} - {1'b0, ma};

   always_comb begin
      logic pos_first;   // true when the result is P - Q with P = ma
      fast_in = '0;
      pos_first = 1'b0;
      case (op)
         OP_ADD, OP_SUB: begin
            if ((na == nb) == (op == OP_ADD)) begin
               fast_in = {na, sum_w[MAG_W-1:0]};
            end else begin
               pos_first = (op == OP_ADD) ? !na : !na;
               if (pos_first)
                  fast_in = a_m_b[MAG_W] ? {1'b1, b_m_a[MAG_W-1:0]}
                                         : {1'b0, a_m_b[MAG_W-1:0]};
               else
                  fast_in = b_m_a[MAG_W] ? {1'b1, a_m_b[MAG_W-1:0]}
                                         : {1'b0, b_m_a[MAG_W-1:0]};
            end
         end
         OP_MUL:  fast_in = {na ^ nb, 31'd0};
         default: fast_in = '0;
      endcase
      div_in.rem  = '0;
      div_in.quo  = ma;
      div_in.dvs  = mb;
      div_in.sign = na ^ nb;
      div_in.dz   = (mb == '0);
   end

   // Low 31 bits of the product, registered after the multiplier; zero
   // for every other operation so the merge leaves those results alone
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= (op == OP_MUL) ? 32'(ma * mb) : 32'd0;
      end
   end

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         is_div_ff[0] <= (op == OP_DIV);
         fast_ff[0]   <= fast_in;
         // Merge product into the second slot once it is registered
         is_div_ff[1] <= is_div_ff[0];
         fast_ff[1]   <= fast_ff[0] | {1'b0, prod_ff[MAG_W-1:0]};
         for (int i = 2; i < DEPTH; i++) begin
            is_div_ff[i] <= is_div_ff[i-1];
            fast_ff[i]   <= fast_ff[i-1];
         end
         if (is_div_ff[DEPTH-1]) begin
            out_data_ff <= div_out.dz ? 32'd0 : {div_out.sign, div_out.quo};
            out_dz_ff   <= div_out.dz;
         end else begin
            out_data_ff <= fast_ff[DEPTH-1];
            out_dz_ff   <= 1'b0;
         end
      end
   end

   // Divider takes the operands from a hold register loaded alongside the fast
   // path input register, so its 31 stages end aligned with the last fast slot.
   div_stage_type div_hold_ff;
   always_ff @(posedge clock) begin
      if (advance) div_hold_ff <= div_in;
   end

   smalu_div u_div (
      .clock    (clock),
      .enable   (advance),
      .stage_in (div_hold_ff),
      .stage_out(div_out)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_dz_ff;

endmodule

// ===== rtl/smalu_div.sv =====
// ---------------------------------------------------------------------------
// smalu_div: pipelined restoring divider
// Produces one quotient bit per stage; advances only when enable is high.
// ---------------------------------------------------------------------------
module smalu_div (
   input  logic                     clock,
   input  logic                     enable,
   input  smalu_pkg::div_stage_type stage_in,
   output smalu_pkg::div_stage_type stage_out
);
   import smalu_pkg::*;

   div_stage_type pipe_ff [MAG_W];
   div_stage_type pipe_in [MAG_W];

   always_comb begin
      for (int i = 0; i < MAG_W; i++) begin
         div_stage_type src;
         logic [MAG_W:0] trial;
         src = (i == 0) ? stage_in : pipe_ff[i-1];
         pipe_in[i] = src;
         // Shift the next dividend bit (held in quo) into the remainder
         trial = {src.rem, src.quo[MAG_W-1]} - {1'b0, src.dvs};
         if (!trial[MAG_W]) begin
            pipe_in[i].rem = trial[MAG_W-1:0];
            pipe_in[i].quo = {src.quo[MAG_W-2:0], 1'b1};
         end else begin
            pipe_in[i].rem = {src.rem[MAG_W-2:0], src.quo[MAG_W-1]};
            pipe_in[i].quo = {src.quo[MAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < MAG_W; i++) pipe_ff[i] <= pipe_in[i];
      end
   end

   assign stage_out = pipe_ff[MAG_W-1];

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: stream-level check of the sign-magnitude ALU
// Feeds directed and random operations through the req_ channel in bursts,
// stalls the rsp_ channel on its own pattern, and compares every response
// beat with an in-order queue of predicted results.
// ---------------------------------------------------------------------------
module testbench;
   import smalu_pkg::*;

   typedef struct packed {
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        dz;
   } alu_rsp_type;

   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES   = 80;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [31:0] MAG_MASK = 32'h7fff_ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = OP_ADD;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   int unsigned errors = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   bit          stim_done = 1'b0;

   sign_magnitude_alu u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // P - Q on magnitudes, sign set when Q is larger
   function automatic logic [31:0] magnitude_diff(logic [31:0] p, logic [31:0] q);
      if (p >= q) return p - q;
      return SIGN_BIT | (q - p);
   endfunction

   function automatic alu_rsp_type compute_alu(alu_req_type r);
      alu_rsp_type o;
      logic        na, nb;
      logic [31:0] ma, mb, sgn;
      logic [63:0] prod;
      na = r.a[31];
      nb = r.b[31];
      ma = r.a & MAG_MASK;
      mb = r.b & MAG_MASK;
      sgn = (na != nb) ? SIGN_BIT : 32'd0;
      o.dz = 1'b0;
      o.result = '0;
      case (r.op)
         OP_ADD: begin
            if (na == nb) o.result = (na ? SIGN_BIT : 32'd0) | ((ma + mb) & MAG_MASK);
            else if (!na) o.result = magnitude_diff(ma, mb);
            else o.result = magnitude_diff(mb, ma);
         end
         OP_SUB: begin
            if (na == nb) o.result = na ? magnitude_diff(mb, ma) : magnitude_diff(ma, mb);
            else o.result = (na ? SIGN_BIT : 32'd0) | ((ma + mb) & MAG_MASK);
         end
         OP_MUL: begin
            prod = {32'd0, ma} * {32'd0, mb};
            o.result = sgn | (prod[31:0] & MAG_MASK);
         end
         default: begin
            if (mb == 0) o.dz = 1'b1;
            else o.result = sgn | ((ma / mb) & MAG_MASK);
         end
      endcase
      return o;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return {$urandom_range(0, 1) == 1, 31'd0};
         1: return {$urandom_range(0, 1) == 1, 31'h7fff_ffff};
         2: return {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 15))};
         3: return {$urandom_range(0, 1) == 1, 15'd0, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic push_req(op_type op, logic [31:0] a, logic [31:0] b);
      alu_req_type r;
      r.op = op;
      r.a = a;
      r.b = b;
      pending_reqs.push_back(r);
   endtask

   initial begin
      op_type ops[4];
      ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
      foreach (ops[i]) begin
         push_req(ops[i], 32'h0000_0000, 32'h0000_0000);
         push_req(ops[i], 32'hffff_ffff, 32'hffff_ffff);
         push_req(ops[i], 32'h7fff_ffff, 32'h8000_0001);
         push_req(ops[i], 32'h8000_0000, 32'h0000_0005);
         push_req(ops[i], 32'h8000_0003, 32'h0000_0007);
      end
      push_req(OP_ADD, 32'h8000_0001, 32'hffff_ffff);  // minus sum wraps to minus zero
      push_req(OP_DIV, 32'h8000_0009, 32'h8000_0000);  // divide by minus zero
      push_req(OP_MUL, 32'h8000_0000, 32'h0000_0009);  // unlike signs, zero magnitude
      push_req(OP_SUB, 32'h8000_0002, 32'h8000_0007);
      repeat (850) push_req(op_type'($urandom_range(0, 3)), random_word(), random_word());
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts of beats with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(compute_alu(pending_reqs.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_reqs[0].op;
               req_tdata <= {pending_reqs[0].b, pending_reqs[0].a};
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
               stim_done <= 1'b1;
            end
         end
      end
   end

   // monitor: compare each response beat with the oldest prediction
   always @(posedge clock) begin
      alu_rsp_type exp_rsp;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected beat result=%h dz=%b", $time, rsp_tdata, rsp_tuser);
               errors = errors + 1;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_tdata !== exp_rsp.result) begin
                  $display("%0t: result expected %h actual %h", $time, exp_rsp.result,
                           rsp_tdata);
                  errors = errors + 1;
               end
               if (rsp_tuser !== exp_rsp.dz) begin
                  $display("%0t: divide_by_zero expected %b actual %b", $time, exp_rsp.dz,
                           rsp_tuser);
                  errors = errors + 1;
               end
            end
         end
         // stall pattern: long open stretches, short and long holds
         case ($time / 400 % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) == 0);
            default: rsp_tready <= ($time / 40 % 3 != 0);
         endcase
      end
   end

   initial begin
      wait (stim_done || idle_cycles >= WATCHDOG_LIMIT);
      while (expected_rsps.size() > 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      if (!stim_done || expected_rsps.size() > 0) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (errors == 0 && expected_rsps.size() == 0) begin
            $display("CHECK OK");
         end else begin
            $display("CHECK FAILED");
         end
         $finish;
      end
   end

endmodule
